// ===== src/tdf_pkg.sv =====
// Shared types, constants and microprogram for the trial-division factorizer.
// No dependencies; used by trial_division_factorizer_core.
package tdf_pkg;

	localparam int NUMBER_WIDTH_DEF = 31;
	localparam int MAX_RESULTS      = 30;
	localparam int EXP_W            = 5;
	localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
	localparam int UPC_W            = 4;

	typedef logic [UPC_W-1:0] upc_t;

	// Wait condition that must hold before a step executes.
	typedef enum logic [2:0] {
		W_NONE,
		W_INPUT,
		W_DIV,
		W_PUSH,
		W_OUT
	} wait_t;

	// Jump condition, evaluated when the step executes.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_REM_LE1,
		C_SQ_GT,
		C_DIV_NZ,
		C_NOREP,
		C_NOROOM,
		C_SKIP_EMIT
	} cond_t;

	// Datapath action of a step.
	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_DIV_START,
		A_HIT,
		A_EMIT_D1,
		A_EMIT_DEX,
		A_EMIT_REM,
		A_EMIT_ONE,
		A_NEXT_D,
		A_FLUSH
	} act_t;

	typedef struct packed {
		wait_t wt;
		act_t  act;
		cond_t cnd;
		upc_t  target;
	} ucw_t;

	// Step addresses
	localparam upc_t S_IDLE   = 4'd0;
	localparam upc_t S_TRIV_T = 4'd1;
	localparam upc_t S_LOOP   = 4'd2;
	localparam upc_t S_DIV    = 4'd3;
	localparam upc_t S_DWAIT  = 4'd4;
	localparam upc_t S_HIT    = 4'd5;
	localparam upc_t S_EMIT1  = 4'd6;
	localparam upc_t S_AGAIN  = 4'd7;
	localparam upc_t S_MISS   = 4'd8;
	localparam upc_t S_EMITX  = 4'd9;
	localparam upc_t S_NEXT   = 4'd10;
	localparam upc_t S_TAIL   = 4'd11;
	localparam upc_t S_EMITR  = 4'd12;
	localparam upc_t S_FLUSH  = 4'd13;
	localparam upc_t S_TRIV   = 4'd14;

	// Microprogram ROM
	function automatic ucw_t ucode(input upc_t a);
		ucw_t w;
		w = '{wt: W_NONE, act: A_NONE, cnd: C_ALWAYS, target: S_IDLE};
		case (a)
			S_IDLE:   w = '{wt: W_INPUT, act: A_LOAD,      cnd: C_NEVER,     target: S_IDLE};
			S_TRIV_T: w = '{wt: W_NONE,  act: A_NONE,      cnd: C_REM_LE1,   target: S_TRIV};
			S_LOOP:   w = '{wt: W_NONE,  act: A_NONE,      cnd: C_SQ_GT,     target: S_TAIL};
			S_DIV:    w = '{wt: W_NONE,  act: A_DIV_START, cnd: C_NEVER,     target: S_IDLE};
			S_DWAIT:  w = '{wt: W_DIV,   act: A_NONE,      cnd: C_DIV_NZ,    target: S_MISS};
			S_HIT:    w = '{wt: W_NONE,  act: A_HIT,       cnd: C_NOREP,     target: S_DIV};
			S_EMIT1:  w = '{wt: W_PUSH,  act: A_EMIT_D1,   cnd: C_NOROOM,    target: S_FLUSH};
			S_AGAIN:  w = '{wt: W_NONE,  act: A_NONE,      cnd: C_ALWAYS,    target: S_DIV};
			S_MISS:   w = '{wt: W_NONE,  act: A_NONE,      cnd: C_SKIP_EMIT, target: S_NEXT};
			S_EMITX:  w = '{wt: W_PUSH,  act: A_EMIT_DEX,  cnd: C_NOROOM,    target: S_FLUSH};
			S_NEXT:   w = '{wt: W_NONE,  act: A_NEXT_D,    cnd: C_ALWAYS,    target: S_LOOP};
			S_TAIL:   w = '{wt: W_NONE,  act: A_NONE,      cnd: C_REM_LE1,   target: S_FLUSH};
			S_EMITR:  w = '{wt: W_PUSH,  act: A_EMIT_REM,  cnd: C_NEVER,     target: S_IDLE};
			S_FLUSH:  w = '{wt: W_OUT,   act: A_FLUSH,     cnd: C_ALWAYS,    target: S_IDLE};
			S_TRIV:   w = '{wt: W_PUSH,  act: A_EMIT_ONE,  cnd: C_ALWAYS,    target: S_FLUSH};
			default:  w = '{wt: W_NONE,  act: A_NONE,      cnd: C_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== src/tdf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by trial_division_factorizer_core.
module tdf_div #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    sh;
	logic          ge;

	assign sh = {acc_q, quo_q[W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (ge) begin
				acc_q <= W'(sh - {1'b0, dvs_q});
			end else begin
				acc_q <= sh[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = acc_q;

endmodule

// ===== src/trial_division_factorizer_core.sv =====
// Trial-division prime factorizer, microcoded control over a divider.
// Worst case near 46000 trial divisors for a 31-bit prime. One number is
// handled at a time: a new one is taken only in the idle step.
// Reset (arst_n, async, active low) idles the sequencer, clears repeat_q.
// Depends on tdf_pkg and tdf_div.
module trial_division_factorizer_core #(
	parameter int NUMBER_WIDTH = tdf_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	// input items
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [NUMBER_WIDTH-1:0]      number,
	// result items
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [NUMBER_WIDTH-1:0]      factor,
	output logic [tdf_pkg::EXP_W-1:0]    exponent,
	output logic                         last
);

	localparam int W    = NUMBER_WIDTH;
	localparam int SQ_W = NUMBER_WIDTH + 1;

	// Sequencer
	tdf_pkg::upc_t upc_q;
	tdf_pkg::ucw_t uw;
	logic          go;
	logic          jump;

	// Datapath: remaining value, divisor, divisor squared, exponent, count
	logic [W-1:0]                 rem_q;
	logic [W-1:0]                 d_q;
	logic [SQ_W-1:0]              sq_q;
	logic [tdf_pkg::EXP_W-1:0]    ex_q;
	logic [tdf_pkg::CNT_W-1:0]    cnt_q;
	logic                         repeat_q;

	// One result held back so the final one can carry last
	logic                         pend_valid_q;
	logic [W-1:0]                 pend_fac_q;
	logic [tdf_pkg::EXP_W-1:0]    pend_exp_q;

	// Output register
	logic                         out_valid_q;
	logic [W-1:0]                 factor_q;
	logic [tdf_pkg::EXP_W-1:0]    exponent_q;
	logic                         last_q;
	logic                         out_free;

	// Divider
	logic         div_start;
	logic         div_busy;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;

	// Emission select
	logic                      emit_en;
	logic [W-1:0]              emit_fac;
	logic [tdf_pkg::EXP_W-1:0] emit_exp;

	assign uw       = tdf_pkg::ucode(upc_q);
	assign out_free = !out_valid_q || out_ready;

	// Wait conditions gate execution of the current step
	always_comb begin
		case (uw.wt)
			tdf_pkg::W_NONE:  go = 1'b1;
			tdf_pkg::W_INPUT: go = in_valid;
			tdf_pkg::W_DIV:   go = !div_busy;
			tdf_pkg::W_PUSH:  go = !pend_valid_q || out_free;
			tdf_pkg::W_OUT:   go = out_free;
			default:          go = 1'b0;
		endcase
	end

	// Branch conditions
	always_comb begin
		case (uw.cnd)
			tdf_pkg::C_NEVER:     jump = 1'b0;
			tdf_pkg::C_ALWAYS:    jump = 1'b1;
			tdf_pkg::C_REM_LE1:   jump = rem_q <= W'(1);
			tdf_pkg::C_SQ_GT:     jump = sq_q > {1'b0, rem_q};
			tdf_pkg::C_DIV_NZ:    jump = div_rem != '0;
			tdf_pkg::C_NOREP:     jump = !repeat_q;
			// evaluated on an emit step, so look at the count after it
			tdf_pkg::C_NOROOM:    jump = (cnt_q + 1'b1) == tdf_pkg::CNT_W'(tdf_pkg::MAX_RESULTS);
			tdf_pkg::C_SKIP_EMIT: jump = (ex_q == '0) || repeat_q;
			default:              jump = 1'b0;
		endcase
	end

	always_comb begin
		emit_en  = 1'b0;
		emit_fac = d_q;
		emit_exp = tdf_pkg::EXP_W'(1);
		case (uw.act)
			tdf_pkg::A_EMIT_D1: begin
				emit_en = 1'b1;
			end
			tdf_pkg::A_EMIT_DEX: begin
				emit_en  = 1'b1;
				emit_exp = ex_q;
			end
			tdf_pkg::A_EMIT_REM: begin
				emit_en  = 1'b1;
				emit_fac = rem_q;
			end
			tdf_pkg::A_EMIT_ONE: begin
				emit_en  = 1'b1;
				emit_fac = W'(1);
				emit_exp = '0;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	assign div_start = go && (uw.act == tdf_pkg::A_DIV_START);

	tdf_div #(
		.W(W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rem_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Config register; ready every cycle, writes belong between numbers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= 1'b0;
		end else if (cfg_valid) begin
			repeat_q <= cfg_data;
		end
	end

	// Step counter, control flags and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= tdf_pkg::S_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			// output loads on a push behind a held result or on the flush
			if (go && ((emit_en && pend_valid_q) || (uw.act == tdf_pkg::A_FLUSH))) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				upc_q <= jump ? uw.target : upc_q + 1'b1;
				if (uw.act == tdf_pkg::A_LOAD) begin
					cnt_q <= '0;
				end
				if (emit_en) begin
					cnt_q        <= cnt_q + 1'b1;
					pend_valid_q <= 1'b1;
				end
				if (uw.act == tdf_pkg::A_FLUSH) begin
					pend_valid_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			case (uw.act)
				tdf_pkg::A_LOAD: begin
					rem_q <= number;
					d_q   <= W'(2);
					sq_q  <= SQ_W'(4);
					ex_q  <= '0;
				end
				tdf_pkg::A_HIT: begin
					rem_q <= div_quo;
					if (ex_q != '1) begin
						ex_q <= ex_q + 1'b1;
					end
				end
				tdf_pkg::A_NEXT_D: begin
					// (d+1)^2 = d^2 + 2d + 1
					sq_q <= sq_q + {d_q, 1'b1};
					d_q  <= d_q + 1'b1;
					ex_q <= '0;
				end
				default: begin
				end
			endcase
			if (emit_en) begin
				pend_fac_q <= emit_fac;
				pend_exp_q <= emit_exp;
				if (pend_valid_q) begin
					factor_q   <= pend_fac_q;
					exponent_q <= pend_exp_q;
					last_q     <= 1'b0;
				end
			end
			if (uw.act == tdf_pkg::A_FLUSH) begin
				factor_q   <= pend_fac_q;
				exponent_q <= pend_exp_q;
				last_q     <= 1'b1;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (uw.wt == tdf_pkg::W_INPUT);
	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign exponent  = exponent_q;
	assign last      = last_q;

	// A new number is only taken once the held-back result has been flushed
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_valid_q)
		else $error("input taken while a result is still held");

	// Divider is never restarted mid-operation
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// Result count never passes the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tdf_pkg::CNT_W'(tdf_pkg::MAX_RESULTS))
		else $error("result count above cap");

	// Exponent zero only on the single trivial result
	a_trivial: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && exponent_q == '0) |-> (last_q && factor_q == W'(1)))
		else $error("zero exponent on a non-trivial result");

endmodule
